[design/segx_pkg.sv]
package segx_pkg;

    localparam int FIELD_W = 16;              // coordinate field width
    localparam int DIFF_W  = FIELD_W + 1;     // point differences
    localparam int PROD_W  = 2 * DIFF_W;      // one cross product term
    localparam int SUM_W   = PROD_W + 1;      // det, tn, un
    localparam int MAG_W   = SUM_W - 1;       // |det|, |tn|
    localparam int Q_W     = FIELD_W;         // quotient magnitude bits
    localparam int NUM_W   = MAG_W + Q_W;     // |tn| * |axis delta|
    localparam int THR_W   = 16;

    typedef logic signed [FIELD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic [MAG_W-1:0]          mag_t;
    typedef logic [NUM_W-1:0]          num_t;

    // Cramer terms and what the later stages still need
    typedef struct packed {
        logic   valid;
        sum_t   det;
        sum_t   tn;
        sum_t   un;
        diff_t  d1x;
        diff_t  d1y;
        coord_t ax0;
        coord_t ay0;
    } cramer_t;

    // one word in flight through the divider, one axis
    typedef struct packed {
        logic           valid;
        logic           hit;
        logic           neg;
        num_t           rem;
        mag_t           den;
        coord_t         base;
        logic [Q_W-1:0] q;
    } div_t;

    function automatic mag_t mag_of(input sum_t v);
        sum_t n;
        n = v[SUM_W-1] ? -v : v;
        return n[MAG_W-1:0];
    endfunction

    function automatic logic [Q_W-1:0] diff_mag(input diff_t v);
        diff_t n;
        n = v[DIFF_W-1] ? -v : v;
        return n[Q_W-1:0];
    endfunction

endpackage

[design/segx_cramer.sv]
module segx_cramer
    import segx_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  logic    in_ok,
    input  coord_t  a_start_x,
    input  coord_t  a_start_y,
    input  coord_t  a_end_x,
    input  coord_t  a_end_y,
    input  coord_t  b_start_x,
    input  coord_t  b_start_y,
    input  coord_t  b_end_x,
    input  coord_t  b_end_y,
    output cramer_t cr
);

    localparam int EFF = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int SH  = FIELD_W - EFF;

    coord_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;

    // sign extend from the effective coordinate size
    assign ax0 = (a_start_x <<< SH) >>> SH;
    assign ay0 = (a_start_y <<< SH) >>> SH;
    assign ax1 = (a_end_x <<< SH) >>> SH;
    assign ay1 = (a_end_y <<< SH) >>> SH;
    assign bx0 = (b_start_x <<< SH) >>> SH;
    assign by0 = (b_start_y <<< SH) >>> SH;
    assign bx1 = (b_end_x <<< SH) >>> SH;
    assign by1 = (b_end_y <<< SH) >>> SH;

    // stage 1: differences
    logic   s1_valid_reg;
    diff_t  d1x_reg, d1y_reg, d2x_reg, d2y_reg, wx_reg, wy_reg;
    coord_t s1_ax0_reg, s1_ay0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1x_reg    <= DIFF_W'(ax0) - DIFF_W'(ax1);
            d1y_reg    <= DIFF_W'(ay0) - DIFF_W'(ay1);
            d2x_reg    <= DIFF_W'(bx0) - DIFF_W'(bx1);
            d2y_reg    <= DIFF_W'(by0) - DIFF_W'(by1);
            wx_reg     <= DIFF_W'(ax0) - DIFF_W'(bx0);
            wy_reg     <= DIFF_W'(ay0) - DIFF_W'(by0);
            s1_ax0_reg <= ax0;
            s1_ay0_reg <= ay0;
        end
    end

    // stage 2: six products
    logic   s2_valid_reg;
    prod_t  p_det_a_reg, p_det_b_reg, p_tn_a_reg, p_tn_b_reg, p_un_a_reg, p_un_b_reg;
    diff_t  s2_d1x_reg, s2_d1y_reg;
    coord_t s2_ax0_reg, s2_ay0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_det_a_reg <= PROD_W'(d1x_reg) * PROD_W'(d2y_reg);
            p_det_b_reg <= PROD_W'(d1y_reg) * PROD_W'(d2x_reg);
            p_tn_a_reg  <= PROD_W'(wx_reg) * PROD_W'(d2y_reg);
            p_tn_b_reg  <= PROD_W'(wy_reg) * PROD_W'(d2x_reg);
            p_un_a_reg  <= PROD_W'(d1y_reg) * PROD_W'(wx_reg);
            p_un_b_reg  <= PROD_W'(d1x_reg) * PROD_W'(wy_reg);
            s2_d1x_reg  <= d1x_reg;
            s2_d1y_reg  <= d1y_reg;
            s2_ax0_reg  <= s1_ax0_reg;
            s2_ay0_reg  <= s1_ay0_reg;
        end
    end

    // stage 3: det, tn, un
    cramer_t cr_reg;
    cramer_t cr_next;

    always_comb
    begin
        cr_next.valid = s2_valid_reg;
        cr_next.det   = SUM_W'(p_det_a_reg) - SUM_W'(p_det_b_reg);
        cr_next.tn    = SUM_W'(p_tn_a_reg) - SUM_W'(p_tn_b_reg);
        cr_next.un    = SUM_W'(p_un_a_reg) - SUM_W'(p_un_b_reg);
        cr_next.d1x   = s2_d1x_reg;
        cr_next.d1y   = s2_d1y_reg;
        cr_next.ax0   = s2_ax0_reg;
        cr_next.ay0   = s2_ay0_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cr_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            cr_reg <= cr_next;
        end
    end

    assign cr = cr_reg;

endmodule

[design/segx_classify.sv]
module segx_classify
    import segx_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [THR_W-1:0] threshold,
    input  cramer_t          cr,
    output div_t             div_x,
    output div_t             div_y
);

    // stage 4: parallel and interior tests
    logic           s4_valid_reg, s4_hit_reg;
    logic           negx_reg, negy_reg;
    mag_t           det_mag_reg, tn_mag_reg;
    logic [Q_W-1:0] mx_reg, my_reg;
    coord_t         s4_ax0_reg, s4_ay0_reg;

    logic det_pos, det_nz, t_in, u_in, par, hit_next;
    mag_t det_mag;

    always_comb
    begin
        det_nz  = (cr.det != '0);
        det_pos = !cr.det[SUM_W-1] && det_nz;
        det_mag = mag_of(cr.det);
        par     = (det_mag <= MAG_W'(threshold));
        if (det_pos)
        begin
            t_in = (cr.tn > 0) && (cr.tn < cr.det);
            u_in = (cr.un > 0) && (cr.un < cr.det);
        end
        else
        begin
            t_in = (cr.tn < 0) && (cr.tn > cr.det);
            u_in = (cr.un < 0) && (cr.un > cr.det);
        end
        hit_next = det_nz && !par && t_in && u_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_valid_reg <= cr.valid;
        end
    end

    // end minus start is -d1, so its sign flips
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_hit_reg  <= hit_next;
            det_mag_reg <= det_mag;
            tn_mag_reg  <= mag_of(cr.tn);
            negx_reg    <= cr.tn[SUM_W-1] ^ cr.det[SUM_W-1] ^ (cr.d1x > 0);
            negy_reg    <= cr.tn[SUM_W-1] ^ cr.det[SUM_W-1] ^ (cr.d1y > 0);
            mx_reg      <= diff_mag(cr.d1x);
            my_reg      <= diff_mag(cr.d1y);
            s4_ax0_reg  <= cr.ax0;
            s4_ay0_reg  <= cr.ay0;
        end
    end

    // stage 5: dividend magnitudes, zeroed on a miss
    div_t dx_reg, dy_reg, dx_next, dy_next;

    always_comb
    begin
        dx_next.valid = s4_valid_reg;
        dx_next.hit   = s4_hit_reg;
        dx_next.neg   = negx_reg;
        dx_next.rem   = s4_hit_reg ? NUM_W'(tn_mag_reg) * NUM_W'(mx_reg) : '0;
        dx_next.den   = det_mag_reg;
        dx_next.base  = s4_ax0_reg;
        dx_next.q     = '0;
        dy_next.valid = s4_valid_reg;
        dy_next.hit   = s4_hit_reg;
        dy_next.neg   = negy_reg;
        dy_next.rem   = s4_hit_reg ? NUM_W'(tn_mag_reg) * NUM_W'(my_reg) : '0;
        dy_next.den   = det_mag_reg;
        dy_next.base  = s4_ay0_reg;
        dy_next.q     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dx_reg.valid <= 1'b0;
            dy_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    assign div_x = dx_reg;
    assign div_y = dy_reg;

endmodule

[design/segx_divider.sv]
module segx_divider
    import segx_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  div_t din,
    output div_t dout
);

    // restoring division, one quotient bit per stage, MSB first;
    // on a hit the quotient is below the axis delta, so Q_W bits suffice
    div_t pipe_reg  [Q_W];
    div_t pipe_next [Q_W];

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        div_t cur;
        num_t shifted;
        logic ge;

        if (k == 0)
        begin : g_first
            assign cur = din;
        end
        else
        begin : g_rest
            assign cur = pipe_reg[k-1];
        end

        always_comb
        begin
            shifted                   = NUM_W'(cur.den) << (Q_W - 1 - k);
            ge                        = (cur.rem >= shifted);
            pipe_next[k]              = cur;
            pipe_next[k].rem          = ge ? cur.rem - shifted : cur.rem;
            pipe_next[k].q[Q_W-1-k]   = ge;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < Q_W; k++)
            begin
                pipe_reg[k].valid <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < Q_W; k++)
            begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    assign dout = pipe_reg[Q_W-1];

endmodule

[design/segment_intersection.sv]
// channel | direction | handshake            | word
// in      | input     | in_valid / in_stall   | a_*, b_* start and end points
// out     | output    | out_valid / out_stall | hit, cross_x, cross_y
// cfg     | input     | cfg_valid / cfg_ready | cfg_data -> parallel_threshold
//
// One word per cycle while no stalled full output register holds the pipeline; a word
// passes the Cramer terms, the tests and dividends, the one-bit-per-stage divider and an output register.
// rst_n clears all valid bits and sets the threshold to 0.
// A stalled full output register freezes the whole pipeline and raises in_stall.
module segment_intersection
    import segx_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  coord_t           a_start_x,
    input  coord_t           a_start_y,
    input  coord_t           a_end_x,
    input  coord_t           a_end_y,
    input  coord_t           b_start_x,
    input  coord_t           b_start_y,
    input  coord_t           b_end_x,
    input  coord_t           b_end_y,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             hit,
    output coord_t           cross_x,
    output coord_t           cross_y,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [THR_W-1:0] cfg_data
);

    logic             en;
    logic [THR_W-1:0] threshold_reg;
    cramer_t          cr;
    div_t             div_x, div_y, res_x, res_y;

    assign en        = !(out_valid && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            threshold_reg <= cfg_data;
        end
    end

    segx_cramer #(.COORD_BITS(COORD_BITS)) u_cramer (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_ok     (in_valid),
        .a_start_x (a_start_x),
        .a_start_y (a_start_y),
        .a_end_x   (a_end_x),
        .a_end_y   (a_end_y),
        .b_start_x (b_start_x),
        .b_start_y (b_start_y),
        .b_end_x   (b_end_x),
        .b_end_y   (b_end_y),
        .cr        (cr)
    );

    segx_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .threshold (threshold_reg),
        .cr        (cr),
        .div_x     (div_x),
        .div_y     (div_y)
    );

    segx_divider u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (div_x),
        .dout  (res_x)
    );

    segx_divider u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (div_y),
        .dout  (res_y)
    );

    // final add of the signed quotient to the start point
    logic              out_valid_reg, hit_reg;
    coord_t            cross_x_reg, cross_y_reg;
    logic signed [Q_W+1:0] qx, qy;
    coord_t            px, py;

    always_comb
    begin
        qx = res_x.neg ? -(Q_W+2)'(res_x.q) : (Q_W+2)'(res_x.q);
        qy = res_y.neg ? -(Q_W+2)'(res_y.q) : (Q_W+2)'(res_y.q);
        px = res_x.hit ? FIELD_W'((Q_W+2)'(res_x.base) + qx) : '0;
        py = res_y.hit ? FIELD_W'((Q_W+2)'(res_y.base) + qy) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= res_x.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg     <= res_x.hit;
            cross_x_reg <= px;
            cross_y_reg <= py;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign cross_x   = cross_x_reg;
    assign cross_y   = cross_y_reg;

    // both axes carry the same word
    assert property (@(posedge clk) disable iff (!rst_n)
        res_x.valid == res_y.valid && (!res_x.valid || res_x.hit == res_y.hit))
        else $error("x and y dividers out of step");

    // the division must have run to completion
    assert property (@(posedge clk) disable iff (!rst_n)
        res_x.valid && res_x.hit |-> res_x.rem < NUM_W'(res_x.den))
        else $error("divider remainder not below the divisor");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> cross_x == '0 && cross_y == '0)
        else $error("miss with nonzero point");

endmodule
